// File: rtl/core/thsh_pkg.sv
`default_nettype none
package thsh_pkg;

	// field widths
	localparam int unsigned CNT_W   = 20;
	localparam int unsigned STEPS_W = 16;
	localparam int unsigned PHASE_W = 3;
	localparam int unsigned AXES    = 3;
	localparam int unsigned IDX_W   = 2;

	// phase codes
	localparam logic [PHASE_W-1:0] PH_IDLE  = 3'd0;
	localparam logic [PHASE_W-1:0] PH_SEEK  = 3'd1;
	localparam logic [PHASE_W-1:0] PH_BACK1 = 3'd2;
	localparam logic [PHASE_W-1:0] PH_BACK2 = 3'd3;
	localparam logic [PHASE_W-1:0] PH_BACK3 = 3'd4;
	localparam logic [PHASE_W-1:0] PH_DONE  = 3'd5;

	// configuration register indexes
	localparam logic [IDX_W-1:0] REG_TIMEOUT = 2'd0;
	localparam logic [IDX_W-1:0] REG_BACK1   = 2'd1;
	localparam logic [IDX_W-1:0] REG_BACK2   = 2'd2;
	localparam logic [IDX_W-1:0] REG_BACK3   = 2'd3;

	// configuration reset values
	localparam logic [CNT_W-1:0]   TIMEOUT_RST = 20'd500000;
	localparam logic [STEPS_W-1:0] BACK1_RST   = 16'd4000;
	localparam logic [STEPS_W-1:0] BACK2_RST   = 16'd1000;
	localparam logic [STEPS_W-1:0] BACK3_RST   = 16'd400;

	// direction pattern while seeking: first and second clockwise
	localparam logic [AXES-1:0] SEEK_DIR = 3'b011;

	typedef struct packed {
		logic [CNT_W-1:0]   timeout;
		logic [STEPS_W-1:0] back1;
		logic [STEPS_W-1:0] back2;
		logic [STEPS_W-1:0] back3;
	} cfg_t;

	typedef struct packed {
		logic [PHASE_W-1:0] phase;
		logic [AXES-1:0]    found;
		logic [CNT_W-1:0]   count;
		logic [STEPS_W-1:0] remain;
		logic [AXES-1:0]    dir;
		logic               timed_out;
	} state_t;

endpackage
`default_nettype wire

// File: rtl/core/three_axis_stepper_homing.sv
// Homing sequencer for three stepper motors, one input beat per step tick.
// Input channel (item_valid / item_stall): start_request and the three
// active-low limit levels of one tick. Result channel (result_valid /
// result_stall): the step pulses of that tick plus directions, phase,
// found flags and timeout flag as they stand after the tick.
// Configuration channel (cfg_valid / cfg_ready, always ready): cfg_index
// selects timeout or one of the three back-off counts; write only while idle.
// A beat accepted into the input register is processed by the combinational step
// logic into the result register and offered on the result port from there.
// One beat is taken per cycle while the result is not stalled. A stalled result
// holds; a new beat is still taken while the input register is free, and
// item_stall rises only when both registers are full and the result is stalled.
// Reset clears the sequence to idle, clears flags and counters, and loads
// the configuration defaults (timeout 500000, back-off 4000, 1000, 400).
`default_nettype none
module three_axis_stepper_homing (
	input  wire                                 clk,
	input  wire                                 arst_n,
	// input channel
	input  wire                                 item_valid,
	output logic                                item_stall,
	input  wire                                 start_request,
	input  wire                                 limit_first_level,
	input  wire                                 limit_second_level,
	input  wire                                 limit_third_level,
	// result channel
	output logic                                result_valid,
	input  wire                                 result_stall,
	output logic                                pulse_first,
	output logic                                pulse_second,
	output logic                                pulse_third,
	output logic                                heading_first,
	output logic                                heading_second,
	output logic                                heading_third,
	output logic [thsh_pkg::PHASE_W-1:0]        phase_code,
	output logic                                found_first,
	output logic                                found_second,
	output logic                                found_third,
	output logic                                seek_timed_out,
	// configuration channel
	input  wire                                 cfg_valid,
	output logic                                cfg_ready,
	input  wire  [thsh_pkg::IDX_W-1:0]          cfg_index,
	input  wire  [thsh_pkg::CNT_W-1:0]          cfg_data
);

	thsh_pkg::cfg_t               cfg_q;
	thsh_pkg::state_t             state_q;
	thsh_pkg::state_t             state_nxt;
	logic [thsh_pkg::AXES-1:0]    pulses_nxt;
	logic [thsh_pkg::AXES-1:0]    pulses_q;
	logic                         valid_s1;
	logic                         start_s1;
	logic [thsh_pkg::AXES-1:0]    limits_s1;
	logic                         result_free;
	logic                         advance;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout <= thsh_pkg::TIMEOUT_RST;
			cfg_q.back1   <= thsh_pkg::BACK1_RST;
			cfg_q.back2   <= thsh_pkg::BACK2_RST;
			cfg_q.back3   <= thsh_pkg::BACK3_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				thsh_pkg::REG_TIMEOUT: cfg_q.timeout <= cfg_data;
				thsh_pkg::REG_BACK1:   cfg_q.back1   <= cfg_data[thsh_pkg::STEPS_W-1:0];
				thsh_pkg::REG_BACK2:   cfg_q.back2   <= cfg_data[thsh_pkg::STEPS_W-1:0];
				thsh_pkg::REG_BACK3:   cfg_q.back3   <= cfg_data[thsh_pkg::STEPS_W-1:0];
				default: ;
			endcase
		end
	end

	// pipeline flow control
	assign result_free = !result_valid || !result_stall;
	assign advance     = valid_s1 && result_free;
	assign item_stall  = valid_s1 && !result_free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			start_s1  <= start_request;
			limits_s1 <= {limit_third_level, limit_second_level, limit_first_level};
		end
	end

	// step logic
	thsh_step u_step (
		.cur    (state_q),
		.cfg    (cfg_q),
		.start  (start_s1),
		.limits (limits_s1),
		.nxt    (state_nxt),
		.pulses (pulses_nxt)
	);

	// sequence state doubles as the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= '0;
			pulses_q     <= '0;
			result_valid <= 1'b0;
		end else begin
			if (advance) begin
				state_q  <= state_nxt;
				pulses_q <= pulses_nxt;
			end
			if (result_free) begin
				result_valid <= valid_s1;
			end
		end
	end

	// result fields
	assign pulse_first    = pulses_q[0];
	assign pulse_second   = pulses_q[1];
	assign pulse_third    = pulses_q[2];
	assign heading_first  = state_q.dir[0];
	assign heading_second = state_q.dir[1];
	assign heading_third  = state_q.dir[2];
	assign phase_code     = state_q.phase;
	assign found_first    = state_q.found[0];
	assign found_second   = state_q.found[1];
	assign found_third    = state_q.found[2];
	assign seek_timed_out = state_q.timed_out;

endmodule
`default_nettype wire

// File: rtl/core/thsh_step.sv
`default_nettype none
module thsh_step (
	input  wire thsh_pkg::state_t                 cur,
	input  wire thsh_pkg::cfg_t                   cfg,
	input  wire logic                             start,
	input  wire logic [thsh_pkg::AXES-1:0]        limits,
	output thsh_pkg::state_t                      nxt,
	output logic [thsh_pkg::AXES-1:0]             pulses
);

	logic [thsh_pkg::AXES-1:0]    unfound;
	logic [thsh_pkg::AXES-1:0]    found_new;
	logic [thsh_pkg::STEPS_W-1:0] remain_dec;
	logic                         remain_nz;

	// seek decisions per motor
	assign unfound    = ~cur.found;
	assign found_new  = cur.found | (unfound & ~limits);
	assign remain_nz  = (cur.remain != '0);
	assign remain_dec = cur.remain - {{(thsh_pkg::STEPS_W-1){1'b0}}, remain_nz};

	// one tick of the homing sequence
	always_comb begin
		nxt    = cur;
		pulses = '0;
		case (cur.phase)
			thsh_pkg::PH_SEEK: begin
				nxt.found = found_new;
				pulses    = unfound & limits;
				if (cur.count >= cfg.timeout) begin
					nxt.timed_out = 1'b1;
					nxt.phase     = thsh_pkg::PH_DONE;
				end else if (&found_new) begin
					nxt.phase  = thsh_pkg::PH_BACK1;
					nxt.remain = cfg.back1;
					nxt.dir[0] = 1'b0;
				end
				if (cur.count != '1) begin
					nxt.count = cur.count + 1'b1;
				end
			end
			thsh_pkg::PH_BACK1, thsh_pkg::PH_BACK2, thsh_pkg::PH_BACK3: begin
				nxt.remain = remain_dec;
				if (remain_nz) begin
					case (cur.phase)
						thsh_pkg::PH_BACK1: pulses = 3'b001;
						thsh_pkg::PH_BACK2: pulses = 3'b010;
						default:            pulses = 3'b100;
					endcase
				end
				// advance on the tick the count runs out
				if (remain_dec == '0) begin
					case (cur.phase)
						thsh_pkg::PH_BACK1: begin
							nxt.phase  = thsh_pkg::PH_BACK2;
							nxt.remain = cfg.back2;
							nxt.dir[1] = 1'b0;
						end
						thsh_pkg::PH_BACK2: begin
							nxt.phase  = thsh_pkg::PH_BACK3;
							nxt.remain = cfg.back3;
							nxt.dir[2] = 1'b1;
						end
						default: begin
							nxt.phase = thsh_pkg::PH_DONE;
						end
					endcase
				end
			end
			default: begin
				if (cur.phase != thsh_pkg::PH_DONE) begin
					nxt.phase = thsh_pkg::PH_IDLE;
				end
				if (start) begin
					nxt.phase     = thsh_pkg::PH_SEEK;
					nxt.found     = '0;
					nxt.count     = '0;
					nxt.timed_out = 1'b0;
					nxt.remain    = '0;
					nxt.dir       = thsh_pkg::SEEK_DIR;
				end
			end
		endcase
	end

endmodule
`default_nettype wire

// File: rtl/core/thsh_checker.sv
`default_nettype none
module thsh_checker (
	input wire                                 clk,
	input wire                                 arst_n,
	input wire                                 result_valid,
	input wire                                 result_stall,
	input wire                                 pulse_first,
	input wire                                 pulse_second,
	input wire                                 pulse_third,
	input wire  [thsh_pkg::PHASE_W-1:0]        phase_code,
	input wire                                 found_first,
	input wire                                 found_second,
	input wire                                 found_third,
	input wire                                 seek_timed_out
);

	logic in_backoff;

	assign in_backoff = (phase_code == thsh_pkg::PH_BACK1) ||
		(phase_code == thsh_pkg::PH_BACK2) || (phase_code == thsh_pkg::PH_BACK3);

	// a stalled result beat stays
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(phase_code))
		else $error("result beat dropped or changed under stall");

	// back-off only after all three limits and no timeout
	a_backoff_found: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && in_backoff |->
			found_first && found_second && found_third && !seek_timed_out)
		else $error("back-off without all limits found");

	// back-off drives at most one motor per tick
	a_backoff_one: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && in_backoff |-> $onehot0({pulse_third, pulse_second, pulse_first}))
		else $error("several motors pulsed during back-off");

	// idle never steps a motor
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && phase_code == thsh_pkg::PH_IDLE |->
			!pulse_first && !pulse_second && !pulse_third)
		else $error("pulse while idle");

endmodule

bind three_axis_stepper_homing thsh_checker u_thsh_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.result_valid   (result_valid),
	.result_stall   (result_stall),
	.pulse_first    (pulse_first),
	.pulse_second   (pulse_second),
	.pulse_third    (pulse_third),
	.phase_code     (phase_code),
	.found_first    (found_first),
	.found_second   (found_second),
	.found_third    (found_third),
	.seek_timed_out (seek_timed_out)
);
`default_nettype wire
